@@ rtl/ctsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctsc_pkg
// Shared types and constants for the configuration text structure checker:
// payload structs, lexical modes, verdict codes and the lexer state record.
// ----------------------------------------------------------------------------
package ctsc_pkg;

    // Counter width for line and byte counts, and their saturation value.
    localparam int CNT_W = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Width of the length limit register.
    localparam int LEN_W = 16;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16384);

    // Verdict codes.
    localparam logic [2:0] VERD_OK    = 3'd0;
    localparam logic [2:0] VERD_LONG  = 3'd1;
    localparam logic [2:0] VERD_UTF16 = 3'd2;
    localparam logic [2:0] VERD_NUL   = 3'd3;
    localparam logic [2:0] VERD_CROSS = 3'd4;
    localparam logic [2:0] VERD_OPENQ = 3'd5;
    localparam logic [2:0] VERD_OPENC = 3'd6;

    // Characters the lexer looks for.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_BOM_A = 8'hFF;
    localparam logic [7:0] CHAR_BOM_B = 8'hFE;

    // Lexical modes.
    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_QUOTED,
        MODE_LINE,
        MODE_BLOCK
    } lex_mode_t;

    // Lexer state that one judged byte can change.
    typedef struct packed {
        lex_mode_t        mode;
        logic [CNT_W-1:0] line_count;
        logic [CNT_W-1:0] opening_line;
        logic [2:0]       first_error;
        logic [CNT_W-1:0] first_error_line;
    } lex_state_t;

    // Input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       carries_byte;
        logic       is_last;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [2:0]       verdict;
        logic [CNT_W-1:0] error_line;
    } out_item_t;

endpackage

@@ rtl/ctsc_judge.sv @@
// ----------------------------------------------------------------------------
// ctsc_judge
// Judges one text byte against its lookahead byte and returns the updated
// lexer state, plus a flag that tells whether the lookahead byte was consumed
// as the second half of a two-character token.
// ----------------------------------------------------------------------------
module ctsc_judge (
    input  logic [7:0]          cur_byte,
    input  logic [7:0]          next_byte,
    input  ctsc_pkg::lex_state_t st_in,
    output ctsc_pkg::lex_state_t st_out,
    output logic                consumed
);
    import ctsc_pkg::*;

    logic is_nl;
    logic stop;
    logic breaks_line;

    assign is_nl       = (cur_byte == CHAR_LF) || (cur_byte == CHAR_CR);
    assign breaks_line = (cur_byte == CHAR_LF) ||
                         ((cur_byte == CHAR_CR) && (next_byte != CHAR_LF));

    // Mode transitions, error capture and line counting for one byte.
    always_comb begin
        st_out   = st_in;
        consumed = 1'b0;
        stop     = 1'b0;
        if (st_in.first_error == VERD_OK) begin
            if (cur_byte == CHAR_NUL) begin
                st_out.first_error      = VERD_NUL;
                st_out.first_error_line = st_in.line_count;
            end else begin
                case (st_in.mode)
                    MODE_LINE: begin
                        if (is_nl) begin
                            st_out.mode = MODE_NORMAL;
                        end
                    end
                    MODE_BLOCK: begin
                        if (cur_byte == CHAR_STAR && next_byte == CHAR_SLASH) begin
                            st_out.mode = MODE_NORMAL;
                            consumed    = 1'b1;
                            stop        = 1'b1;
                        end
                    end
                    MODE_QUOTED: begin
                        if (cur_byte == CHAR_QUOTE) begin
                            st_out.mode = MODE_NORMAL;
                        end else if (is_nl) begin
                            st_out.first_error      = VERD_CROSS;
                            st_out.first_error_line = st_in.opening_line;
                            stop                    = 1'b1;
                        end
                    end
                    default: begin
                        if (cur_byte == CHAR_SLASH && next_byte == CHAR_SLASH) begin
                            st_out.mode = MODE_LINE;
                            consumed    = 1'b1;
                            stop        = 1'b1;
                        end else if (cur_byte == CHAR_SLASH && next_byte == CHAR_STAR) begin
                            st_out.mode         = MODE_BLOCK;
                            st_out.opening_line = st_in.line_count;
                            consumed            = 1'b1;
                            stop                = 1'b1;
                        end else if (cur_byte == CHAR_QUOTE) begin
                            st_out.mode         = MODE_QUOTED;
                            st_out.opening_line = st_in.line_count;
                        end
                    end
                endcase
                if (!stop && breaks_line && (st_in.line_count != CNT_MAX)) begin
                    st_out.line_count = st_in.line_count + CNT_ONE;
                end
            end
        end
    end

endmodule

@@ rtl/ctsc_core.sv @@
// ----------------------------------------------------------------------------
// ctsc_core
// Holds the per-file checker state and the result register. Each registered
// item is folded into the state; the final item of a file also
// judges the held lookahead byte, forms the verdict and clears the state.
// ----------------------------------------------------------------------------
module ctsc_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      item_valid,
    input  ctsc_pkg::in_item_t        item,
    output logic                      item_take,
    input  logic [ctsc_pkg::LEN_W-1:0] max_length,
    output logic                      m_valid,
    input  logic                      m_ready,
    output ctsc_pkg::out_item_t       m_data
);
    import ctsc_pkg::*;

    lex_state_t       st_reg, st_next;
    logic [7:0]       held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    logic             skip_reg, skip_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       first_byte_reg, first_byte_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    lex_state_t       st_mark;
    lex_state_t       st_judged1, st_after1;
    lex_state_t       st_judged2, st_final;
    logic             consumed1;
    logic             consumed2;
    logic             run1;
    logic             run2;
    logic             is_bom;
    logic             proc;

    // A non-final item always proceeds; a final one needs room in the result register.
    assign proc      = item_valid && (!item.is_last || !out_valid_reg || m_ready);
    assign item_take = proc;

    assign is_bom = ((first_byte_reg == CHAR_BOM_A) && (item.data_byte == CHAR_BOM_B)) ||
                    ((first_byte_reg == CHAR_BOM_B) && (item.data_byte == CHAR_BOM_A));

    // Byte-order mark check on the second byte of the file.
    always_comb begin
        st_mark = st_reg;
        if (item.carries_byte && (byte_count_reg == CNT_ONE) && is_bom &&
            (st_reg.first_error == VERD_OK)) begin
            st_mark.first_error      = VERD_UTF16;
            st_mark.first_error_line = CNT_ONE;
        end
    end

    // Judge the held byte, using the new byte as lookahead.
    assign run1 = item.carries_byte && held_valid_reg && !skip_reg;

    ctsc_judge u_judge_byte (
        .cur_byte  (held_reg),
        .next_byte (item.data_byte),
        .st_in     (st_mark),
        .st_out    (st_judged1),
        .consumed  (consumed1)
    );

    assign st_after1       = run1 ? st_judged1 : st_mark;
    assign held_next       = item.carries_byte ? item.data_byte : held_reg;
    assign held_valid_next = item.carries_byte ? 1'b1 : held_valid_reg;
    assign skip_next       = item.carries_byte ? (run1 && consumed1) : skip_reg;

    // At end of file, judge the last held byte with no lookahead.
    assign run2 = held_valid_next && !skip_next;

    ctsc_judge u_judge_last (
        .cur_byte  (held_next),
        .next_byte (CHAR_NUL),
        .st_in     (st_after1),
        .st_out    (st_judged2),
        .consumed  (consumed2)
    );

    assign st_final = run2 ? st_judged2 : st_after1;

    // Byte counting, verdict selection and next state.
    always_comb begin
        first_byte_next = first_byte_reg;
        byte_count_next = byte_count_reg;
        if (item.carries_byte) begin
            if (byte_count_reg == '0) begin
                first_byte_next = item.data_byte;
            end
            if (byte_count_reg != CNT_MAX) begin
                byte_count_next = byte_count_reg + CNT_ONE;
            end
        end

        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        st_next        = st_reg;

        if (proc) begin
            if (item.is_last) begin
                out_valid_next = 1'b1;
                if (byte_count_next >= {{(CNT_W-LEN_W){1'b0}}, max_length}) begin
                    out_data_next.verdict    = VERD_LONG;
                    out_data_next.error_line = CNT_ONE;
                end else if (st_final.first_error != VERD_OK) begin
                    out_data_next.verdict    = st_final.first_error;
                    out_data_next.error_line = st_final.first_error_line;
                end else if (st_final.mode == MODE_QUOTED) begin
                    out_data_next.verdict    = VERD_OPENQ;
                    out_data_next.error_line = st_final.opening_line;
                end else if (st_final.mode == MODE_BLOCK) begin
                    out_data_next.verdict    = VERD_OPENC;
                    out_data_next.error_line = st_final.opening_line;
                end else begin
                    out_data_next.verdict    = VERD_OK;
                    out_data_next.error_line = CNT_ONE;
                end
            end else begin
                st_next = st_after1;
            end
        end
    end

    // State registers; the final item of a file returns them to reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn || (proc && item.is_last)) begin
            st_reg.mode             <= MODE_NORMAL;
            st_reg.line_count       <= CNT_ONE;
            st_reg.opening_line     <= CNT_ONE;
            st_reg.first_error      <= VERD_OK;
            st_reg.first_error_line <= CNT_ONE;
            held_reg                <= '0;
            held_valid_reg          <= 1'b0;
            skip_reg                <= 1'b0;
            byte_count_reg          <= '0;
            first_byte_reg          <= '0;
        end else if (proc) begin
            st_reg         <= st_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            skip_reg       <= skip_next;
            byte_count_reg <= byte_count_next;
            first_byte_reg <= first_byte_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ rtl/config_text_structure_checker.sv @@
// ----------------------------------------------------------------------------
// config_text_structure_checker
// Checks a configuration text for structural soundness, one byte per transfer.
// The verdict is registered in the result register after the final transfer
// of a file passes the input register. Throughput: one transfer per cycle.
// A final transfer waits only while an unaccepted verdict holds the result.
// Reset: synchronous, active low; clears all checker state, max_length = 16384.
// ----------------------------------------------------------------------------
module config_text_structure_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ctsc_pkg::in_item_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ctsc_pkg::out_item_t        m_data,
    input  logic                       cfg_wr_en,
    input  logic [ctsc_pkg::LEN_W-1:0] cfg_wr_data
);
    import ctsc_pkg::*;

    logic             in_valid_reg;
    in_item_t         in_data_reg;
    logic [LEN_W-1:0] max_length_reg;
    logic             core_take;

    // Input register: refilled whenever it is empty or being drained.
    assign s_ready = !in_valid_reg || core_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Length limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= LEN_RESET;
        end else if (cfg_wr_en) begin
            max_length_reg <= cfg_wr_data;
        end
    end

    ctsc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item       (in_data_reg),
        .item_take  (core_take),
        .max_length (max_length_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the configuration text structure checker. Files are
// built as byte streams (directed corner files, then mostly well-formed random
// text with some noise), sent in bursts with random gaps, and every verdict is
// compared against a cycle-free copy of the checker kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctsc_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 650;
    localparam int MAX_REPORTS  = 10;

    // Block ports.
    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    in_item_t          s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    out_item_t         m_data;
    logic              cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]  cfg_wr_data = '0;

    // Stimulus and checking bookkeeping.
    in_item_t          pending_items[$];
    out_item_t         expected_verdicts[$];
    int unsigned       counted_items = 0;
    int unsigned       fail_count    = 0;
    int unsigned       cycle_count   = 0;
    int unsigned       burst_left    = 0;
    int unsigned       gap_left      = 0;
    logic [15:0]       ready_pattern = '1;
    int unsigned       ready_age     = 0;

    // Shadow copy of the checker state.
    logic [LEN_W-1:0]  shadow_limit = LEN_RESET;
    lex_mode_t         scan_mode;
    logic [7:0]        scan_held;
    bit                scan_held_ok;
    bit                scan_skip;
    logic [CNT_W-1:0]  scan_line;
    logic [CNT_W-1:0]  scan_open;
    logic [CNT_W-1:0]  scan_count;
    logic [7:0]        scan_first;
    logic [2:0]        scan_err;
    logic [CNT_W-1:0]  scan_err_line;

    config_text_structure_checker dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Shadow checker
    // ------------------------------------------------------------------------

    // Return to the start-of-file state; the length limit is kept.
    function automatic void clear_scan();
        scan_mode     = MODE_NORMAL;
        scan_held     = '0;
        scan_held_ok  = 1'b0;
        scan_skip     = 1'b0;
        scan_line     = CNT_ONE;
        scan_open     = CNT_ONE;
        scan_count    = '0;
        scan_first    = '0;
        scan_err      = VERD_OK;
        scan_err_line = CNT_ONE;
    endfunction

    // Only the first error of a file is kept.
    function automatic void note_error(input logic [2:0] code, input logic [CNT_W-1:0] line);
        if (scan_err == VERD_OK) begin
            scan_err      = code;
            scan_err_line = line;
        end
    endfunction

    // Judge byte c with the byte that follows it; true when that byte is
    // swallowed as the second half of a two-character token.
    function automatic bit judge_byte(input logic [7:0] c, input logic [7:0] n);
        bit is_break;
        is_break = (c == CHAR_LF) || (c == CHAR_CR);
        if (scan_err != VERD_OK) return 1'b0;
        if (c == CHAR_NUL) begin
            note_error(VERD_NUL, scan_line);
            return 1'b0;
        end
        case (scan_mode)
            MODE_LINE: begin
                if (is_break) scan_mode = MODE_NORMAL;
            end
            MODE_BLOCK: begin
                if (c == CHAR_STAR && n == CHAR_SLASH) begin
                    scan_mode = MODE_NORMAL;
                    return 1'b1;
                end
            end
            MODE_QUOTED: begin
                if (c == CHAR_QUOTE) begin
                    scan_mode = MODE_NORMAL;
                end else if (is_break) begin
                    note_error(VERD_CROSS, scan_open);
                    return 1'b0;
                end
            end
            default: begin
                if (c == CHAR_SLASH && n == CHAR_SLASH) begin
                    scan_mode = MODE_LINE;
                    return 1'b1;
                end else if (c == CHAR_SLASH && n == CHAR_STAR) begin
                    scan_mode = MODE_BLOCK;
                    scan_open = scan_line;
                    return 1'b1;
                end else if (c == CHAR_QUOTE) begin
                    scan_mode = MODE_QUOTED;
                    scan_open = scan_line;
                end
            end
        endcase
        // A CR followed by LF is left for the LF to count.
        if (c == CHAR_LF || (c == CHAR_CR && n != CHAR_LF)) begin
            if (scan_line != CNT_MAX) scan_line++;
        end
        return 1'b0;
    endfunction

    // Advance the shadow checker by one accepted transfer and queue the
    // verdict when it closes a file.
    function automatic void predict_item(input in_item_t it);
        out_item_t res;
        if (it.carries_byte) begin
            if (scan_count == 0) begin
                scan_first = it.data_byte;
            end else if (scan_count == 1) begin
                if ((scan_first == CHAR_BOM_A && it.data_byte == CHAR_BOM_B) ||
                    (scan_first == CHAR_BOM_B && it.data_byte == CHAR_BOM_A)) begin
                    note_error(VERD_UTF16, CNT_ONE);
                end
            end
            if (scan_count != CNT_MAX) scan_count++;
            if (scan_held_ok && !scan_skip) begin
                scan_skip = judge_byte(scan_held, it.data_byte);
            end else begin
                scan_skip = 1'b0;
            end
            scan_held    = it.data_byte;
            scan_held_ok = 1'b1;
        end
        if (!it.is_last) return;

        // The held byte is judged against the end of the file.
        if (scan_held_ok && !scan_skip) void'(judge_byte(scan_held, CHAR_NUL));

        if (scan_count >= CNT_W'(shadow_limit)) begin
            res.verdict    = VERD_LONG;
            res.error_line = CNT_ONE;
        end else if (scan_err != VERD_OK) begin
            res.verdict    = scan_err;
            res.error_line = scan_err_line;
        end else if (scan_mode == MODE_QUOTED) begin
            res.verdict    = VERD_OPENQ;
            res.error_line = scan_open;
        end else if (scan_mode == MODE_BLOCK) begin
            res.verdict    = VERD_OPENC;
            res.error_line = scan_open;
        end else begin
            res.verdict    = VERD_OK;
            res.error_line = CNT_ONE;
        end
        expected_verdicts.push_back(res);
        clear_scan();
    endfunction

    // ------------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------------

    function automatic void push_item(input logic [7:0] b, input bit carries, input bit last);
        in_item_t it;
        it.data_byte    = b;
        it.carries_byte = carries;
        it.is_last      = last;
        pending_items.push_back(it);
        if (carries || last) counted_items++;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        push_item(b, 1'b1, 1'b0);
    endfunction

    function automatic logic [7:0] plain_char();
        case ($urandom_range(0, 5))
            0:       return 8'h20;
            1:       return 8'h3D;
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] token_char();
        case ($urandom_range(0, 4))
            0:       return CHAR_SLASH;
            1:       return CHAR_STAR;
            2:       return CHAR_QUOTE;
            3:       return CHAR_CR;
            default: return CHAR_LF;
        endcase
    endfunction

    // One line break in any of the three spellings.
    function automatic void push_break();
        case ($urandom_range(0, 2))
            0: push_byte(CHAR_LF);
            1: push_byte(CHAR_CR);
            default: begin
                push_byte(CHAR_CR);
                push_byte(CHAR_LF);
            end
        endcase
    endfunction

    // A random file made of tokens. In tidy files every quote or comment token
    // is closed; the others may leave them open and mix in raw bytes.
    function automatic void add_file(input int unsigned n_tokens, input bit tidy);
        if ($urandom_range(0, 7) == 0) begin
            push_byte($urandom_range(0, 1) ? CHAR_BOM_A : CHAR_BOM_B);
            push_byte($urandom_range(0, 1) ? CHAR_BOM_A : CHAR_BOM_B);
        end
        repeat (n_tokens) begin
            case (tidy ? $urandom_range(0, 9) : $urandom_range(0, 13))
                0, 1, 2, 9: push_byte(plain_char());
                3: push_break();
                4: begin
                    push_byte(CHAR_QUOTE);
                    repeat ($urandom_range(0, 4)) push_byte(plain_char());
                    if (tidy || $urandom_range(0, 1)) push_byte(CHAR_QUOTE);
                    else push_break();
                end
                5: begin
                    push_byte(CHAR_SLASH);
                    push_byte(CHAR_SLASH);
                    repeat ($urandom_range(0, 4)) push_byte(plain_char());
                    if (tidy || $urandom_range(0, 1)) push_break();
                end
                6: begin
                    push_byte(CHAR_SLASH);
                    push_byte(CHAR_STAR);
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(0, 3) == 0) push_break();
                        else push_byte(plain_char());
                    end
                    if (tidy || $urandom_range(0, 1)) begin
                        push_byte(CHAR_STAR);
                        push_byte(CHAR_SLASH);
                    end
                end
                7: push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                8: push_byte(token_char());
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end
        // Close the file either with an empty marker or with a final byte.
        case ($urandom_range(0, 3))
            0:       push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            1:       push_item(token_char(), 1'b1, 1'b1);
            2:       push_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            default: push_item(plain_char(), 1'b1, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------------

    // Wait until every queued transfer is taken and every verdict is back,
    // then let the pipeline settle.
    task automatic wait_idle(input int unsigned settle);
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_verdicts.size() != 0);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= value;
        shadow_limit = value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned target;
        clear_scan();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Corner files under the reset limit.
        push_item(8'h00, 1'b0, 1'b1);
        push_byte(CHAR_BOM_A);
        push_item(CHAR_BOM_B, 1'b1, 1'b1);
        push_byte(CHAR_BOM_B);
        push_item(CHAR_BOM_A, 1'b1, 1'b1);
        push_byte(8'h61);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(CHAR_NUL, 1'b1, 1'b1);
        push_byte(CHAR_LF);
        push_byte(CHAR_QUOTE);
        push_byte(8'h62);
        push_item(CHAR_CR, 1'b1, 1'b1);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_byte(CHAR_CR);
        push_item(CHAR_QUOTE, 1'b1, 1'b1);
        push_byte(CHAR_SLASH);
        push_byte(CHAR_STAR);
        push_item(CHAR_LF, 1'b1, 1'b1);
        push_byte(CHAR_SLASH);
        push_byte(CHAR_SLASH);
        push_byte(CHAR_QUOTE);
        push_byte(CHAR_CR);
        push_byte(CHAR_SLASH);
        push_byte(CHAR_STAR);
        push_byte(CHAR_STAR);
        push_item(CHAR_SLASH, 1'b1, 1'b1);
        wait_idle(DRAIN_CYCLES);

        // A zero limit rejects every file, the empty one included.
        write_max_length('0);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'h61, 1'b1, 1'b1);
        wait_idle(DRAIN_CYCLES);

        // Smallest nonzero limit: only the empty file passes.
        write_max_length(LEN_W'(1));
        push_item(8'h00, 1'b0, 1'b1);
        push_item(CHAR_QUOTE, 1'b1, 1'b1);
        wait_idle(DRAIN_CYCLES);

        // Length wins over the byte-order mark; a lone NUL stays below it.
        write_max_length(LEN_W'(2));
        push_byte(CHAR_BOM_A);
        push_item(CHAR_BOM_B, 1'b1, 1'b1);
        push_item(CHAR_NUL, 1'b1, 1'b1);
        wait_idle(DRAIN_CYCLES);

        // Random phases, each under its own limit.
        target = counted_items + RANDOM_ITEMS;
        while (counted_items < target) begin
            case ($urandom_range(0, 4))
                0:       write_max_length(LEN_RESET);
                1:       write_max_length('1);
                2:       write_max_length(LEN_W'($urandom_range(1, 8)));
                default: write_max_length(LEN_W'($urandom_range(10, 60)));
            endcase
            repeat ($urandom_range(4, 10)) add_file($urandom_range(0, 14), $urandom_range(0, 9) < 7);
            wait_idle(DRAIN_CYCLES);
        end

        // Largest limit: ordinary files stay well below it.
        write_max_length('1);
        add_file(6, 1'b1);
        wait_idle(DRAIN_CYCLES);

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: sends bursts of transfers separated by random gaps.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_item(s_data);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_items.pop_front();
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: ready follows a rotating pattern that changes now and then.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (ready_age == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = 16'($urandom()) | 16'h0001;
                    2:       ready_pattern = 16'h8421;
                    default: ready_pattern = 16'hFFFE;
                endcase
                ready_age = $urandom_range(20, 200);
            end else begin
                ready_age--;
            end
            ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
            m_ready <= ready_pattern[15];
        end
    end

    // Compare every result transfer with the oldest expected verdict.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("Unexpected verdict %0d line %0d at cycle %0d",
                             m_data.verdict, m_data.error_line, cycle_count);
                end
            end else begin
                want = expected_verdicts.pop_front();
                if (m_data.verdict !== want.verdict ||
                    m_data.error_line !== want.error_line) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("Verdict mismatch at cycle %0d: %s %0d line %0d, %s %0d line %0d",
                                 cycle_count, "expected", want.verdict, want.error_line,
                                 "got", m_data.verdict, m_data.error_line);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
